FILE: design/sfpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpm_pkg: shared types and constants of the stereo frame pair matcher
// Field widths, codes, register reset values and the staleness test.
// ----------------------------------------------------------------------------
package sfpm_pkg;

  localparam int TimeW     = 48;
  localparam int SeqW      = 32;
  localparam int CntW      = 32;
  localparam int ScoreW    = SeqW + 1;
  localparam int MaxSkewW  = 20;
  localparam int StaleW    = 24;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;
  localparam int HistDepth = 8;

  localparam logic [MaxSkewW-1:0] MaxSkewRst  = MaxSkewW'(20000);
  localparam logic [StaleW-1:0]   StaleLimRst = StaleW'(200000);
  localparam logic                ReuseRst    = 1'b0;
  localparam logic                SwapRst     = 1'b1;

  typedef enum logic [1:0] {
    ActLeft  = 2'd0,
    ActRight = 2'd1,
    ActTick  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    StPublish = 2'd0,
    StWait    = 2'd1,
    StStale   = 2'd2,
    StSkew    = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxSkew  = 2'd0,
    RegStaleLim = 2'd1,
    RegReuse    = 2'd2,
    RegSwap     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [MaxSkewW-1:0] max_skew;
    logic [StaleW-1:0]   stale_limit;
    logic                reuse;
    logic                swap;
  } cfg_t;

  // Running result of one tick's pair search
  typedef struct packed {
    logic              saw_new;
    logic              saw_fresh;
    logic              have_any;
    logic              have_best;
    logic [TimeW-1:0]  any_skew;
    logic [TimeW-1:0]  skew;
    logic [ScoreW-1:0] score;
    logic [SeqW-1:0]   lseq;
    logic [SeqW-1:0]   rseq;
  } best_t;

  // A frame captured at or after the tick time is never stale
  function automatic logic is_stale(logic [TimeW-1:0]  now,
                                    logic [TimeW-1:0]  t,
                                    logic [StaleW-1:0] lim);
    logic [TimeW-1:0] age;
    age = now - t;
    return (now > t) && (age > TimeW'(lim));
  endfunction

endpackage
`default_nettype wire

FILE: design/sfpm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpm_if: request and result channels of the stereo frame pair matcher
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface sfpm_req_if;
  import sfpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [TimeW-1:0] time_us;

  modport source (output valid, output action, output time_us, input ready);
  modport sink   (input valid, input action, input time_us, output ready);
endinterface

interface sfpm_rsp_if;
  import sfpm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [SeqW-1:0]  left_out_seq;
  logic [SeqW-1:0]  right_out_seq;
  logic [TimeW-1:0] skew_us;
  logic [CntW-1:0]  publish_total;
  logic [CntW-1:0]  skew_drop_total;
  logic [CntW-1:0]  stale_drop_total;
  logic [CntW-1:0]  wait_total;

  modport source (output valid, output status, output left_out_seq, output right_out_seq,
                  output skew_us, output publish_total, output skew_drop_total,
                  output stale_drop_total, output wait_total, input ready);
  modport sink   (input valid, input status, input left_out_seq, input right_out_seq,
                  input skew_us, input publish_total, input skew_drop_total,
                  input stale_drop_total, input wait_total, output ready);
endinterface
`default_nettype wire

FILE: design/stereo_frame_pair_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_frame_pair_matcher: pairs left and right camera frames by timestamp
// Keeps a frame history per side and reports one pairing decision per tick.
// ----------------------------------------------------------------------------
// A frame transfer (action left or right) produces no result. A tick walks
// the left history newest first; each left entry is read from its RAM in
// SLRead and SLWait, and a left entry that is new then has the right history
// streamed in SRRun through the single right RAM read port into the two-stage
// evaluator. SFinish then decides, and one result transfer comes out of the
// tick. The result sits in an output register: the next request is taken
// while it waits.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 max skew, 1 stale limit, 2 reuse, 3 swap); write only while idle.
// ----------------------------------------------------------------------------
module stereo_frame_pair_matcher #(
  parameter  int HISTORY_DEPTH = sfpm_pkg::HistDepth,
  localparam int IdxW          = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
  localparam int FillW         = $clog2(HISTORY_DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sfpm_req_if.sink                           req_i,
  sfpm_rsp_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sfpm_pkg::CfgDataW-1:0] cfg_data_i
);
  import sfpm_pkg::*;

  typedef enum logic [2:0] {
    SIdle,    // take requests
    SLRead,   // present left read address
    SLWait,   // left entry arrives, newness check
    SRRun,    // stream right entries through the evaluator
    SFinish   // decide and load the result register
  } state_e;

  // control
  state_e           state_q, state_d;
  logic [FillW-1:0] i_q, i_d;        // left age index
  logic [FillW-1:0] jr_q, jr_d;      // right age index being issued
  logic             v1_q, v1_d;      // right read data returns this cycle
  logic [TimeW-1:0] now_q, now_d;
  logic [SeqW-1:0]  lq_q, lq_d;
  logic [TimeW-1:0] lt_q, lt_d;
  logic             lstale_q, lstale_d;
  logic [SeqW-1:0]  last_l_q, last_l_d;
  logic [SeqW-1:0]  last_r_q, last_r_d;
  logic [CntW-1:0]  cnt_q [4];
  logic [CntW-1:0]  cnt_d [4];
  cfg_t             cfg_q, cfg_d;

  // result register
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [SeqW-1:0]  out_lseq_q, out_lseq_d;
  logic [SeqW-1:0]  out_rseq_q, out_rseq_d;
  logic [TimeW-1:0] out_skew_q, out_skew_d;
  logic [CntW-1:0]  out_tot_q [4];
  logic [CntW-1:0]  out_tot_d [4];

  logic             req_xfer, rsp_xfer, out_load;
  logic             push_l, push_r, eval_clr;
  logic [SeqW-1:0]  l_seq, r_seq;
  logic [TimeW-1:0] l_time, r_time;
  logic [FillW-1:0] l_fill, r_fill;
  logic             eval_busy;
  best_t            best;
  status_e          status;
  logic [CntW-1:0]  cnt_sum;

  assign req_i.ready = (state_q == SIdle);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign rsp_xfer    = out_valid_q && rsp_o.ready;
  assign push_l      = req_xfer && (action_e'(req_i.action) == ActLeft);
  assign push_r      = req_xfer && (action_e'(req_i.action) == ActRight);
  assign eval_clr    = req_xfer && (action_e'(req_i.action) == ActTick);
  assign out_load    = (state_q == SFinish) && (!out_valid_q || rsp_o.ready);

  sfpm_hist #(.Depth(HISTORY_DEPTH)) u_hist_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_l),
    .time_i   (req_i.time_us),
    .rd_k_i   (i_q[IdxW-1:0]),
    .rd_seq_o (l_seq),
    .rd_time_o(l_time),
    .fill_o   (l_fill)
  );

  sfpm_hist #(.Depth(HISTORY_DEPTH)) u_hist_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_r),
    .time_i   (req_i.time_us),
    .rd_k_i   (jr_q[IdxW-1:0]),
    .rd_seq_o (r_seq),
    .rd_time_o(r_time),
    .fill_o   (r_fill)
  );

  sfpm_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (eval_clr),
    .v_i     (v1_q),
    .cfg_i   (cfg_q),
    .now_i   (now_q),
    .last_r_i(last_r_q),
    .lseq_i  (lq_q),
    .ltime_i (lt_q),
    .lstale_i(lstale_q),
    .rseq_i  (r_seq),
    .rtime_i (r_time),
    .busy_o  (eval_busy),
    .best_o  (best)
  );

  // Decision of the tick from the search summary
  always_comb begin
    if (best.have_best) begin
      status = StPublish;
    end else if (!best.saw_new) begin
      status = StWait;
    end else if (!best.saw_fresh) begin
      status = StStale;
    end else begin
      status = StSkew;
    end
  end

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    jr_d         = jr_q;
    v1_d         = 1'b0;
    now_d        = now_q;
    lq_d         = lq_q;
    lt_d         = lt_q;
    lstale_d     = lstale_q;
    last_l_d     = last_l_q;
    last_r_d     = last_r_q;
    cnt_d        = cnt_q;
    cfg_d        = cfg_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_lseq_d   = out_lseq_q;
    out_rseq_d   = out_rseq_q;
    out_skew_d   = out_skew_q;
    out_tot_d    = out_tot_q;

    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegMaxSkew:  cfg_d.max_skew    = cfg_data_i[MaxSkewW-1:0];
        RegStaleLim: cfg_d.stale_limit = cfg_data_i[StaleW-1:0];
        RegReuse:    cfg_d.reuse       = cfg_data_i[0];
        RegSwap:     cfg_d.swap        = cfg_data_i[0];
        default:     cfg_d             = cfg_q;
      endcase
    end

    if (rsp_xfer) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (eval_clr) begin
          now_d   = req_i.time_us;
          i_d     = '0;
          state_d = SLRead;
        end
      end
      SLRead: begin
        state_d = (i_q == l_fill) ? SFinish : SLWait;
      end
      SLWait: begin
        lq_d     = l_seq;
        lt_d     = l_time;
        lstale_d = is_stale(now_q, l_time, cfg_q.stale_limit);
        if (cfg_q.reuse || (l_seq > last_l_q)) begin
          jr_d    = '0;
          state_d = SRRun;
        end else begin
          i_d     = i_q + FillW'(1);
          state_d = SLRead;
        end
      end
      SRRun: begin
        if (jr_q < r_fill) begin
          jr_d = jr_q + FillW'(1);
          v1_d = 1'b1;
        end else if (!v1_q && !eval_busy) begin
          i_d     = i_q + FillW'(1);
          state_d = SLRead;
        end
      end
      SFinish: begin
        if (out_load) begin
          cnt_d[status] = cnt_q[status] + CntW'(1);
          out_valid_d   = 1'b1;
          out_status_d  = status;
          out_tot_d     = cnt_d;
          if (best.have_best) begin
            out_skew_d = best.skew;
            out_lseq_d = cfg_q.swap ? best.rseq : best.lseq;
            out_rseq_d = cfg_q.swap ? best.lseq : best.rseq;
            last_l_d   = best.lseq;
            last_r_d   = best.rseq;
          end else begin
            out_skew_d = best.have_any ? best.any_skew : '0;
            out_lseq_d = '0;
            out_rseq_d = '0;
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= SIdle;
      i_q               <= '0;
      jr_q              <= '0;
      v1_q              <= 1'b0;
      last_l_q          <= '0;
      last_r_q          <= '0;
      cnt_q             <= '{default: '0};
      cfg_q.max_skew    <= MaxSkewRst;
      cfg_q.stale_limit <= StaleLimRst;
      cfg_q.reuse       <= ReuseRst;
      cfg_q.swap        <= SwapRst;
      out_valid_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      jr_q        <= jr_d;
      v1_q        <= v1_d;
      last_l_q    <= last_l_d;
      last_r_q    <= last_r_d;
      cnt_q       <= cnt_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    lq_q         <= lq_d;
    lt_q         <= lt_d;
    lstale_q     <= lstale_d;
    out_status_q <= out_status_d;
    out_lseq_q   <= out_lseq_d;
    out_rseq_q   <= out_rseq_d;
    out_skew_q   <= out_skew_d;
    out_tot_q    <= out_tot_d;
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.left_out_seq     = out_lseq_q;
  assign rsp_o.right_out_seq    = out_rseq_q;
  assign rsp_o.skew_us          = out_skew_q;
  assign rsp_o.publish_total    = out_tot_q[StPublish];
  assign rsp_o.skew_drop_total  = out_tot_q[StSkew];
  assign rsp_o.stale_drop_total = out_tot_q[StStale];
  assign rsp_o.wait_total       = out_tot_q[StWait];

  assign cnt_sum = cnt_q[0] + cnt_q[1] + cnt_q[2] + cnt_q[3];

  a_pub_skew_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == StPublish) |-> (out_skew_q <= TimeW'(cfg_q.max_skew)))
    else $error("published pair skew above limit");

  a_nopub_zero_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != StPublish) |-> (out_lseq_q == '0 && out_rseq_q == '0))
    else $error("non-publish result carries sequence numbers");

  a_one_event_per_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (cnt_sum == $past(cnt_sum) + CntW'(1)))
    else $error("event counters not stepped by exactly one");

  a_no_result_from_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_l || push_r) |=> !$rose(out_valid_q))
    else $error("frame transfer produced a result");

endmodule
`default_nettype wire

FILE: design/sfpm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpm_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sfpm_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: design/sfpm_hist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpm_hist: frame history of one camera side
// Ring of (seq, time) entries in a RAM; read port addressed by age, k=0 newest.
// ----------------------------------------------------------------------------
module sfpm_hist #(
  parameter  int Depth = sfpm_pkg::HistDepth,
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int FillW = $clog2(Depth + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [sfpm_pkg::TimeW-1:0] time_i,
  input  wire logic [IdxW-1:0]            rd_k_i,
  output logic      [sfpm_pkg::SeqW-1:0]  rd_seq_o,
  output logic      [sfpm_pkg::TimeW-1:0] rd_time_o,
  output logic      [FillW-1:0]           fill_o
);
  import sfpm_pkg::*;

  logic [IdxW-1:0]  head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [SeqW-1:0]  ctr_q, ctr_d;
  logic [IdxW:0]    slot_sum;
  logic [IdxW-1:0]  rd_slot;

  // slot of the k-th newest entry: (head - 1 - k) mod Depth
  always_comb begin
    slot_sum = {1'b0, head_q} + ((IdxW+1)'(Depth - 1) - {1'b0, rd_k_i});
    if (slot_sum >= (IdxW+1)'(Depth)) begin
      rd_slot = IdxW'(slot_sum - (IdxW+1)'(Depth));
    end else begin
      rd_slot = IdxW'(slot_sum);
    end
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    ctr_d  = ctr_q;
    if (push_i) begin
      ctr_d  = ctr_q + SeqW'(1);
      head_d = (head_q == IdxW'(Depth - 1)) ? '0 : head_q + IdxW'(1);
      if (fill_q < FillW'(Depth)) begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      ctr_q  <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      ctr_q  <= ctr_d;
    end
  end

  sfpm_ram #(
    .Width(SeqW + TimeW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (push_i),
    .waddr_i(head_q),
    .wdata_i({ctr_d, time_i}),
    .raddr_i(rd_slot),
    .rdata_o({rd_seq_o, rd_time_o})
  );

  assign fill_o = fill_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth))
    else $error("history fill beyond depth");

  a_head_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q < FillW'(Depth)) |-> (FillW'(head_q) == fill_q))
    else $error("head out of step with fill before wrap");

endmodule
`default_nettype wire

FILE: design/sfpm_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfpm_eval: two-stage pair evaluator
// Stage 1 forms newness, freshness, skew and score; stage 2 updates the best.
// ----------------------------------------------------------------------------
module sfpm_eval (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clr_i,
  input  wire logic                       v_i,
  input  wire sfpm_pkg::cfg_t             cfg_i,
  input  wire logic [sfpm_pkg::TimeW-1:0] now_i,
  input  wire logic [sfpm_pkg::SeqW-1:0]  last_r_i,
  input  wire logic [sfpm_pkg::SeqW-1:0]  lseq_i,
  input  wire logic [sfpm_pkg::TimeW-1:0] ltime_i,
  input  wire logic                       lstale_i,
  input  wire logic [sfpm_pkg::SeqW-1:0]  rseq_i,
  input  wire logic [sfpm_pkg::TimeW-1:0] rtime_i,
  output logic                            busy_o,
  output sfpm_pkg::best_t                 best_o
);
  import sfpm_pkg::*;

  logic              pv_q;
  logic              p_new_q, p_fresh_q;
  logic [TimeW-1:0]  p_skew_q;
  logic [ScoreW-1:0] p_score_q;
  logic [SeqW-1:0]   p_lseq_q, p_rseq_q;
  best_t             best_q, best_d;

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_i) begin
      p_new_q   <= cfg_i.reuse || (rseq_i > last_r_i);
      p_fresh_q <= !lstale_i && !is_stale(now_i, rtime_i, cfg_i.stale_limit);
      p_skew_q  <= (ltime_i > rtime_i) ? ltime_i - rtime_i : rtime_i - ltime_i;
      p_score_q <= {1'b0, lseq_i} + {1'b0, rseq_i};
      p_lseq_q  <= lseq_i;
      p_rseq_q  <= rseq_i;
    end
  end

  // stage 2
  always_comb begin
    best_d = best_q;
    if (clr_i) begin
      best_d = '0;
    end else if (pv_q && p_new_q) begin
      best_d.saw_new = 1'b1;
      if (p_fresh_q) begin
        best_d.saw_fresh = 1'b1;
        if (!best_q.have_any || p_skew_q < best_q.any_skew) begin
          best_d.have_any = 1'b1;
          best_d.any_skew = p_skew_q;
        end
        if (p_skew_q <= TimeW'(cfg_i.max_skew)) begin
          if (!best_q.have_best || p_skew_q < best_q.skew ||
              (p_skew_q == best_q.skew && p_score_q > best_q.score)) begin
            best_d.have_best = 1'b1;
            best_d.skew      = p_skew_q;
            best_d.score     = p_score_q;
            best_d.lseq      = p_lseq_q;
            best_d.rseq      = p_rseq_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign busy_o = pv_q;
  assign best_o = best_q;

endmodule
`default_nettype wire
